// ===== rtl/cle_pkg.sv =====
// Shared constants, codes and types for the console line editor.
`timescale 1ns / 1ps
`default_nettype none
package cle_pkg;

    localparam int LINE_SIZE   = 64;
    localparam int LINE_SLOTS  = 4;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 6;
    localparam int SLOT_W      = 2;
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BS = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SP = 8'd32;

    typedef enum logic [2:0] {
        KIND_STORED   = 3'd0,
        KIND_IGNORED  = 3'd1,
        KIND_ERASED   = 3'd2,
        KIND_DROPPED  = 3'd3,
        KIND_PROMPT   = 3'd4,
        KIND_LINECHAR = 3'd5
    } t_kind;

    // One classified byte; KIND_LINECHAR means "stream the stored line".
    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  ch;
        logic [SLOT_W-1:0]  slot;
        logic [LEN_W-1:0]   len;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_READ,
        BS_DATA
    } t_bstate;

    typedef struct packed {
        logic busy;
        logic line_done;
    } t_back_stat;

endpackage
`default_nettype wire

// ===== rtl/cle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cle_cmdq.sv =====
// Short command queue between the classifier and the result sequencer.
`timescale 1ns / 1ps
`default_nettype none
module cle_cmdq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire cle_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output cle_pkg::t_cmd      o_cmd,
    output logic               o_valid
);

    cle_pkg::t_cmd                       r_mem [cle_pkg::CMDQ_DEPTH];
    logic [cle_pkg::CMDQ_PTR_W-1:0]      r_wp, n_wp;
    logic [cle_pkg::CMDQ_PTR_W-1:0]      r_rp, n_rp;
    logic [cle_pkg::CMDQ_CNT_W-1:0]      r_cnt, n_cnt;
    logic                                do_push;
    logic                                do_pop;

    assign o_full  = (r_cnt == cle_pkg::CMDQ_CNT_W'(cle_pkg::CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cle_front.sv =====
// Front end: accepts received bytes, edits the line and classifies each byte.
`timescale 1ns / 1ps
`default_nettype none
module cle_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic [cle_pkg::CHAR_W-1:0]    i_rx_byte,
    output logic                               o_full,
    input  wire logic                          i_q_full,
    input  wire logic                          i_line_done,
    output logic                               o_cmd_push,
    output cle_pkg::t_cmd                      o_cmd,
    output logic                               o_ram_we,
    output logic [cle_pkg::ADDR_W-1:0]         o_ram_waddr,
    output logic [cle_pkg::CHAR_W-1:0]         o_ram_wdata
);

    logic [cle_pkg::LEN_W-1:0]  r_fill, n_fill;
    logic [cle_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic                       r_busy, n_busy;
    logic                       accept;
    cle_pkg::t_kind             kind;
    logic                       store;

    // Hold off new bytes while the command queue is full or a posted line still reads the store.
    assign o_full = i_q_full || r_busy;
    assign accept = i_push && !o_full;

    // Classify the byte against the current fill level.
    always_comb begin
        store = 1'b0;
        if (i_rx_byte == cle_pkg::CH_CR) begin
            kind = (r_fill == '0) ? cle_pkg::KIND_PROMPT : cle_pkg::KIND_LINECHAR;
        end else if (i_rx_byte == cle_pkg::CH_LF) begin
            kind = cle_pkg::KIND_IGNORED;
        end else if (i_rx_byte == cle_pkg::CH_BS) begin
            kind = (r_fill != '0) ? cle_pkg::KIND_ERASED : cle_pkg::KIND_IGNORED;
        end else if (i_rx_byte == cle_pkg::CH_SP && r_fill == '0) begin
            kind = cle_pkg::KIND_IGNORED;
        end else if (r_fill < cle_pkg::LEN_W'(cle_pkg::LINE_SIZE - 1)) begin
            kind  = cle_pkg::KIND_STORED;
            store = 1'b1;
        end else begin
            kind = cle_pkg::KIND_DROPPED;
        end
    end

    always_comb begin
        n_fill = r_fill;
        n_slot = r_slot;
        n_busy = r_busy;
        if (i_line_done) begin
            n_busy = 1'b0;
        end
        if (accept) begin
            unique case (kind)
                cle_pkg::KIND_STORED: begin
                    n_fill = r_fill + 1'b1;
                end
                cle_pkg::KIND_ERASED: begin
                    n_fill = r_fill - 1'b1;
                end
                cle_pkg::KIND_LINECHAR: begin
                    n_fill = '0;
                    n_busy = 1'b1;
                    n_slot = (r_slot == cle_pkg::SLOT_W'(cle_pkg::LINE_SLOTS - 1))
                             ? '0 : r_slot + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_cmd_push  = accept;
        o_cmd.kind  = kind;
        o_cmd.ch    = i_rx_byte;
        o_cmd.slot  = r_slot;
        o_cmd.len   = (kind == cle_pkg::KIND_LINECHAR) ? r_fill : n_fill;
        o_ram_we    = accept && store;
        o_ram_waddr = cle_pkg::ADDR_W'(r_fill);
        o_ram_wdata = i_rx_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_slot <= '0;
            r_busy <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_slot <= n_slot;
            r_busy <= n_busy;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cle_back.sv =====
// Back end: turns queued commands into results and streams posted lines.
`timescale 1ns / 1ps
`default_nettype none
module cle_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_valid,
    input  wire cle_pkg::t_cmd                 i_cmd,
    output logic                               o_cmd_pop,
    output logic                               o_ram_re,
    output logic [cle_pkg::ADDR_W-1:0]         o_ram_raddr,
    input  wire logic [cle_pkg::CHAR_W-1:0]    i_ram_rdata,
    output cle_pkg::t_back_stat                o_stat,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic [2:0]                         o_event_kind,
    output logic [cle_pkg::CHAR_W-1:0]         o_out_char,
    output logic [cle_pkg::SLOT_W-1:0]         o_line_slot,
    output logic [cle_pkg::LEN_W-1:0]          o_line_length,
    output logic                               o_last_of_run
);

    cle_pkg::t_bstate           r_state, n_state;
    logic [cle_pkg::LEN_W-1:0]  r_idx, n_idx;
    logic [cle_pkg::LEN_W-1:0]  r_len, n_len;
    logic [cle_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic                       r_ov, n_ov;
    cle_pkg::t_kind             r_kind, n_kind;
    logic [cle_pkg::CHAR_W-1:0] r_char, n_char;
    logic [cle_pkg::SLOT_W-1:0] r_oslot, n_oslot;
    logic [cle_pkg::LEN_W-1:0]  r_olen, n_olen;
    logic                       r_last, n_last;
    logic                       out_free;
    logic                       is_line;
    logic                       last_char;

    assign out_free  = !r_ov || i_pop;
    assign is_line   = (i_cmd.kind == cle_pkg::KIND_LINECHAR);
    assign last_char = (r_idx == r_len - 1'b1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cle_pkg::BS_IDLE: begin
                if (i_cmd_valid && out_free && is_line) begin
                    n_state = cle_pkg::BS_READ;
                end
            end
            cle_pkg::BS_READ: begin
                n_state = cle_pkg::BS_DATA;
            end
            cle_pkg::BS_DATA: begin
                if (out_free) begin
                    n_state = last_char ? cle_pkg::BS_IDLE : cle_pkg::BS_READ;
                end
            end
            default: begin
                n_state = cle_pkg::BS_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb begin
        o_cmd_pop        = 1'b0;
        o_ram_re         = 1'b0;
        o_ram_raddr      = cle_pkg::ADDR_W'(r_idx);
        o_stat.busy      = (r_state != cle_pkg::BS_IDLE);
        o_stat.line_done = 1'b0;
        n_idx   = r_idx;
        n_len   = r_len;
        n_slot  = r_slot;
        n_ov    = r_ov && !i_pop;
        n_kind  = r_kind;
        n_char  = r_char;
        n_oslot = r_oslot;
        n_olen  = r_olen;
        n_last  = r_last;
        unique case (r_state)
            cle_pkg::BS_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    if (is_line) begin
                        n_idx  = '0;
                        n_len  = i_cmd.len;
                        n_slot = i_cmd.slot;
                    end else begin
                        n_ov    = 1'b1;
                        n_kind  = i_cmd.kind;
                        n_char  = i_cmd.ch;
                        n_oslot = i_cmd.slot;
                        n_olen  = i_cmd.len;
                        n_last  = 1'b1;
                    end
                end
            end
            cle_pkg::BS_READ: begin
                o_ram_re = 1'b1;
            end
            cle_pkg::BS_DATA: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_kind  = cle_pkg::KIND_LINECHAR;
                    n_char  = i_ram_rdata;
                    n_oslot = r_slot;
                    n_olen  = r_len;
                    n_last  = last_char;
                    n_idx   = r_idx + 1'b1;
                    o_stat.line_done = last_char;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cle_pkg::BS_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_len   <= n_len;
        r_slot  <= n_slot;
        r_kind  <= n_kind;
        r_char  <= n_char;
        r_oslot <= n_oslot;
        r_olen  <= n_olen;
        r_last  <= n_last;
    end

    assign o_empty       = !r_ov;
    assign o_event_kind  = r_kind;
    assign o_out_char    = r_char;
    assign o_line_slot   = r_oslot;
    assign o_line_length = r_olen;
    assign o_last_of_run = r_last;

endmodule
`default_nettype wire

// ===== rtl/console_line_editor.sv =====
// Console line editor: assembles received bytes into a command line.
//
// Input side is a queue: drive i_rx_byte and raise i_push; the byte transfers
// at a clock edge with i_push high and o_full low. Result side is a queue too:
// while o_empty is low the oldest result sits on the o_ ports, and it
// transfers at an edge with i_pop high and o_empty low.
// Each ordinary byte gives one result, through the command queue and output register;
// bytes can follow every cycle while the four-entry command queue has room.
// A carriage return on a non-empty line gives one result per stored
// character, each made by one store read and one output load,
// the last one marked by o_last_of_run. o_full stays high from that carriage
// return until the last character is loaded, since the line store has one
// read port and the next line reuses its entries.
// When the receiver does not pop, the output register holds its result,
// the command queue fills and o_full rises; nothing is dropped.
// Synchronous reset (i_rst_n low) empties the queue and the output, clears
// the fill count and slot counter; the line store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module console_line_editor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_full,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic [2:0]       o_event_kind,
    output logic [7:0]       o_out_char,
    output logic [1:0]       o_line_slot,
    output logic [5:0]       o_line_length,
    output logic             o_last_of_run
);

    logic                          q_push;
    logic                          q_full;
    logic                          q_pop;
    logic                          q_valid;
    cle_pkg::t_cmd                 q_in;
    cle_pkg::t_cmd                 q_out;
    logic                          ram_we;
    logic [cle_pkg::ADDR_W-1:0]    ram_waddr;
    logic [cle_pkg::CHAR_W-1:0]    ram_wdata;
    logic                          ram_re;
    logic [cle_pkg::ADDR_W-1:0]    ram_raddr;
    logic [cle_pkg::CHAR_W-1:0]    ram_rdata;
    cle_pkg::t_back_stat           bstat;

    cle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_rx_byte   (i_rx_byte),
        .o_full      (o_full),
        .i_q_full    (q_full),
        .i_line_done (bstat.line_done),
        .o_cmd_push  (q_push),
        .o_cmd       (q_in),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    cle_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_valid (q_valid)
    );

    cle_ram #(
        .WIDTH (cle_pkg::CHAR_W),
        .DEPTH (cle_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cle_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_out),
        .o_cmd_pop     (q_pop),
        .o_ram_re      (ram_re),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_stat        (bstat),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_event_kind  (o_event_kind),
        .o_out_char    (o_out_char),
        .o_line_slot   (o_line_slot),
        .o_line_length (o_line_length),
        .o_last_of_run (o_last_of_run)
    );

    // No store write while a posted line is being read out.
    a_no_write_during_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !bstat.busy)
        else $error("line store written while a line streams out");

    // The front never pushes into a full command queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    // The end of a line stream leaves a final line character on the output.
    a_line_end_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bstat.line_done |=> (!o_empty && o_last_of_run
                             && o_event_kind == cle_pkg::KIND_LINECHAR))
        else $error("line end not presented as last line character");

endmodule
`default_nettype wire
